// ----- rtl/nisp_pkg.sv -----
package nisp_pkg;

    localparam int LENGTH_BITS = 10;
    localparam logic [7:0] TID_RESET = 8'h40;

    // Event codes
    localparam logic [2:0] EV_HEADER   = 3'd0;
    localparam logic [2:0] EV_NET_HEAD = 3'd1;
    localparam logic [2:0] EV_NET_BYTE = 3'd2;
    localparam logic [2:0] EV_ENTRY    = 3'd3;
    localparam logic [2:0] EV_TS_HEAD  = 3'd4;
    localparam logic [2:0] EV_TS_BYTE  = 3'd5;
    localparam logic [2:0] EV_END_CRC  = 3'd6;
    localparam logic [2:0] EV_BAD_TID  = 3'd7;

    // Register byte addresses
    localparam logic [2:0] ADDR_ACCEPTED_TID = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       section_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  tag_or_table_id;
        logic [9:0]  field_length;
        logic [15:0] primary_id;
        logic [15:0] original_network;
        logic [4:0]  version;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic [7:0]  payload_value;
        logic        duplicate_tag;
        logic [31:0] crc_value;
    } t_out_item;

    typedef enum logic [27:0] {
        PH_IDLE = 28'h0000001, PH_SKIP = 28'h0000002, PH_TID  = 28'h0000004,
        PH_SL1  = 28'h0000008, PH_SL2  = 28'h0000010, PH_NID1 = 28'h0000020,
        PH_NID2 = 28'h0000040, PH_VER  = 28'h0000080, PH_SEC  = 28'h0000100,
        PH_LAST = 28'h0000200, PH_NDL1 = 28'h0000400, PH_NDL2 = 28'h0000800,
        PH_NTAG = 28'h0001000, PH_NLEN = 28'h0002000, PH_NPAY = 28'h0004000,
        PH_TSL1 = 28'h0008000, PH_TSL2 = 28'h0010000, PH_TS1  = 28'h0020000,
        PH_TS2  = 28'h0040000, PH_ON1  = 28'h0080000, PH_ON2  = 28'h0100000,
        PH_EDL1 = 28'h0200000, PH_EDL2 = 28'h0400000, PH_ETAG = 28'h0800000,
        PH_ELEN = 28'h1000000, PH_EPAY = 28'h2000000, PH_PAD  = 28'h4000000,
        PH_CRC  = 28'h8000000
    } t_phase;

endpackage

// ----- rtl/network_info_section_parser.sv -----
// Channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_stall  | i_in  (t_in_item)
// out     | output    | o_out_valid / i_out_stall| o_out (t_out_item)
// cfg     | input     | APB psel/penable/pwrite  | paddr, pwdata, prdata
// One byte is taken per cycle while the input is not stalled; the result of a
// byte shows in the output register in the cycle after it is taken. The tag-seen
// store is read when the tag byte arrives and written on the length byte, so no two accesses overlap.
// Synchronous active-low reset clears the phase; a pass after reset then clears
// all 256 entries of the tag-seen store, one entry per cycle, with the input stalled.
// Otherwise input is stalled only while a result waits and the output is stalled.
module network_info_section_parser
    import nisp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LB = LENGTH_BITS;

    t_phase          r_ph, n_ph;
    logic [7:0]      r_skip, n_skip;
    logic [LB-1:0]   r_sl, n_sl, r_loop, n_loop, r_edl, n_edl;
    logic [7:0]      r_desc, n_desc, r_tag, n_tag;
    logic [31:0]     r_shift, n_shift, r_ids, n_ids;
    logic [15:0]     r_nid, n_nid;
    logic [5:0]      r_verf, n_verf;
    logic [7:0]      r_secn, n_secn;
    logic [7:0]      r_tid_cfg;
    logic            r_seen [256];
    logic            r_clr_busy;
    logic [7:0]      r_clr_addr;
    logic            r_dup;
    logic            n_rd, n_wr, n_emit;
    t_out_item       n_out, r_out;
    logic            r_ovld;
    logic            acc;
    logic [7:0]      b;
    logic [15:0]     two_b;
    logic [31:0]     crc_base;

    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_ACCEPTED_TID) ? {24'd0, r_tid_cfg} : 32'd0;
    assign o_in_stall  = r_clr_busy | (r_ovld & i_out_stall);
    assign acc         = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;
    assign b           = i_in.data_byte;
    assign two_b       = {r_shift[7:0], b};
    assign crc_base    = (r_ph == PH_CRC) ? r_shift : 32'd0;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid_cfg <= TID_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_ACCEPTED_TID) begin
            r_tid_cfg <= pwdata[7:0];
        end
    end

    // Next-state logic for one byte
    always_comb begin
        n_ph = r_ph; n_skip = r_skip; n_sl = r_sl; n_loop = r_loop; n_edl = r_edl;
        n_desc = r_desc; n_tag = r_tag; n_shift = r_shift; n_ids = r_ids;
        n_nid = r_nid; n_verf = r_verf; n_secn = r_secn;
        n_rd = 1'b0; n_wr = 1'b0; n_emit = 1'b0;
        n_out = '0;
        if (i_in.section_start) begin
            n_skip = b;
            n_ph   = (b != 8'd0) ? PH_SKIP : PH_TID;
        end else if (r_ph == PH_IDLE) begin
            n_ph = r_ph;
        end else if (r_ph == PH_SKIP) begin
            n_skip = r_skip - 8'd1;
            if (n_skip == 8'd0) n_ph = PH_TID;
        end else if (r_ph == PH_TID) begin
            if (b != r_tid_cfg) begin
                n_emit = 1'b1;
                n_out.event_kind = EV_BAD_TID;
                n_out.tag_or_table_id = b;
                n_ph = PH_IDLE;
            end else begin
                n_tag = b;
                n_ph  = PH_SL1;
            end
        end else if (r_ph == PH_SL1) begin
            n_shift = {24'd0, b};
            n_ph    = PH_SL2;
        end else if (r_ph == PH_SL2) begin
            n_sl = two_b[LB-1:0];
            if (n_sl == '0) begin
                n_emit = 1'b1;
                n_out.event_kind = EV_END_CRC;
                n_ph = PH_IDLE;
            end else begin
                n_ph = PH_NID1;
            end
        end else if (r_sl <= LB'(4)) begin
            // CRC region
            n_shift = {crc_base[23:0], b};
            n_ph    = PH_CRC;
            if (r_sl != '0) n_sl = r_sl - LB'(1);
            if (n_sl == '0) begin
                n_emit = 1'b1;
                n_out.event_kind = EV_END_CRC;
                n_out.crc_value = n_shift;
                n_ph = PH_IDLE;
            end
        end else begin
            n_sl = r_sl - LB'(1);
            if ((r_ph == PH_NTAG || r_ph == PH_NLEN || r_ph == PH_NPAY ||
                 r_ph == PH_TS1 || r_ph == PH_TS2 || r_ph == PH_ON1 ||
                 r_ph == PH_ON2 || r_ph == PH_EDL1 || r_ph == PH_EDL2 ||
                 r_ph == PH_ETAG || r_ph == PH_ELEN || r_ph == PH_EPAY) &&
                r_loop != '0)
                n_loop = r_loop - LB'(1);
            if ((r_ph == PH_ETAG || r_ph == PH_ELEN || r_ph == PH_EPAY) && r_edl != '0)
                n_edl = r_edl - LB'(1);
            unique case (r_ph)
                PH_NID1: begin n_shift = {24'd0, b}; n_ph = PH_NID2; end
                PH_NID2: begin n_nid = two_b; n_ph = PH_VER; end
                PH_VER:  begin n_verf = b[5:0]; n_ph = PH_SEC; end
                PH_SEC:  begin n_secn = b; n_ph = PH_LAST; end
                PH_LAST: begin
                    n_emit = 1'b1;
                    n_out.event_kind = EV_HEADER;
                    n_out.tag_or_table_id = r_tag;
                    n_out.field_length = 10'(n_sl + LB'(5));
                    n_out.primary_id = r_nid;
                    n_out.version = r_verf[5:1];
                    n_out.current_next = r_verf[0];
                    n_out.section_index = r_secn;
                    n_out.last_section_index = b;
                    n_ph = PH_NDL1;
                end
                PH_NDL1: begin n_shift = {24'd0, b}; n_ph = PH_NDL2; end
                PH_NDL2: begin
                    n_loop = two_b[LB-1:0];
                    n_ph = (n_loop == '0) ? PH_TSL1 : PH_NTAG;
                end
                PH_NTAG: begin n_tag = b; n_rd = 1'b1; n_ph = PH_NLEN; end
                PH_NLEN: begin
                    n_emit = 1'b1;
                    n_wr = 1'b1;
                    n_out.event_kind = EV_NET_HEAD;
                    n_out.tag_or_table_id = r_tag;
                    n_out.field_length = {2'd0, b};
                    n_out.duplicate_tag = r_dup;
                    n_desc = b;
                    if (b == 8'd0) n_ph = (n_loop == '0) ? PH_TSL1 : PH_NTAG;
                    else n_ph = PH_NPAY;
                end
                PH_NPAY: begin
                    n_emit = 1'b1;
                    n_out.event_kind = EV_NET_BYTE;
                    n_out.tag_or_table_id = r_tag;
                    n_out.payload_value = b;
                    n_desc = r_desc - 8'd1;
                    if (n_desc == 8'd0) n_ph = (n_loop == '0) ? PH_TSL1 : PH_NTAG;
                end
                PH_TSL1: begin n_shift = {24'd0, b}; n_ph = PH_TSL2; end
                PH_TSL2: begin
                    n_loop = two_b[LB-1:0];
                    n_ph = (n_loop == '0) ? PH_PAD : PH_TS1;
                end
                PH_TS1:  begin n_ids = {r_ids[23:0], b}; n_ph = PH_TS2; end
                PH_TS2:  begin n_ids = {r_ids[23:0], b}; n_ph = PH_ON1; end
                PH_ON1:  begin n_ids = {r_ids[23:0], b}; n_ph = PH_ON2; end
                PH_ON2:  begin n_ids = {r_ids[23:0], b}; n_ph = PH_EDL1; end
                PH_EDL1: begin n_shift = {24'd0, b}; n_ph = PH_EDL2; end
                PH_EDL2: begin
                    n_edl = two_b[LB-1:0];
                    n_emit = 1'b1;
                    n_out.event_kind = EV_ENTRY;
                    n_out.field_length = n_edl[9:0];
                    n_out.primary_id = r_ids[31:16];
                    n_out.original_network = r_ids[15:0];
                    if (n_edl != '0) n_ph = PH_ETAG;
                    else n_ph = (n_loop == '0) ? PH_PAD : PH_TS1;
                end
                PH_ETAG: begin n_tag = b; n_ph = PH_ELEN; end
                PH_ELEN: begin
                    n_emit = 1'b1;
                    n_out.event_kind = EV_TS_HEAD;
                    n_out.tag_or_table_id = r_tag;
                    n_out.field_length = {2'd0, b};
                    n_out.primary_id = r_ids[31:16];
                    n_out.original_network = r_ids[15:0];
                    n_desc = b;
                    if (b != 8'd0) n_ph = PH_EPAY;
                    else if (n_edl != '0) n_ph = PH_ETAG;
                    else n_ph = (n_loop == '0) ? PH_PAD : PH_TS1;
                end
                PH_EPAY: begin
                    n_emit = 1'b1;
                    n_out.event_kind = EV_TS_BYTE;
                    n_out.tag_or_table_id = r_tag;
                    n_out.primary_id = r_ids[31:16];
                    n_out.original_network = r_ids[15:0];
                    n_out.payload_value = b;
                    n_desc = r_desc - 8'd1;
                    if (n_desc == 8'd0) begin
                        if (n_edl != '0) n_ph = PH_ETAG;
                        else n_ph = (n_loop == '0) ? PH_PAD : PH_TS1;
                    end
                end
                default: n_ph = r_ph;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_skip <= '0; r_sl <= '0; r_loop <= '0; r_edl <= '0;
            r_desc <= '0; r_tag <= '0; r_shift <= '0; r_ids <= '0;
            r_nid <= '0; r_verf <= '0; r_secn <= '0;
        end else if (acc) begin
            r_ph <= n_ph; r_skip <= n_skip; r_sl <= n_sl; r_loop <= n_loop;
            r_edl <= n_edl; r_desc <= n_desc; r_tag <= n_tag; r_shift <= n_shift;
            r_ids <= n_ids; r_nid <= n_nid; r_verf <= n_verf; r_secn <= n_secn;
        end
    end

    // Clearing pass over the tag-seen store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 8'd1;
            if (r_clr_addr == 8'hFF) r_clr_busy <= 1'b0;
        end
    end

    // Tag-seen store: cleared entry by entry, then set on the length byte
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_seen[r_clr_addr] <= 1'b0;
        end else if (acc && n_wr) begin
            r_seen[r_tag] <= 1'b1;
        end
    end

    // Registered read on the tag byte
    always_ff @(posedge i_clk) begin
        if (acc && n_rd) r_dup <= r_seen[b];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (acc && n_emit) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && n_emit) r_out <= n_out;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
    import nisp_pkg::*;
;

    // Local phase codes for the predictor
    typedef enum int {
        S_IDLE, S_SKIP, S_TID, S_SL1, S_SL2, S_NID1, S_NID2, S_VER, S_SEC, S_LAST,
        S_NDL1, S_NDL2, S_NTAG, S_NLEN, S_NPAY, S_TSL1, S_TSL2, S_TS1, S_TS2,
        S_ON1, S_ON2, S_EDL1, S_EDL2, S_ETAG, S_ELEN, S_EPAY, S_PAD, S_CRC
    } t_pred_phase;

    localparam logic [9:0] LEN_MASK = 10'h3FF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    network_info_section_parser u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state
    t_pred_phase pr_phase;
    logic [7:0]  pr_skip;
    logic [9:0]  pr_sec_left;
    logic [9:0]  pr_loop_left;
    logic [9:0]  pr_edesc_left;
    logic [7:0]  pr_desc_left;
    logic [7:0]  pr_tag;
    logic [31:0] pr_shift;
    logic [15:0] pr_net_id;
    logic [5:0]  pr_ver_flags;
    logic [7:0]  pr_sec_num;
    logic [31:0] pr_entry_ids;
    logic        pr_seen [256];
    logic [7:0]  pr_accept_tid;

    t_out_item   event_queue [$];
    int          fail_count;
    int          event_count;
    int          byte_count;
    int          idle_pct;
    int          stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_out_item blank_event(logic [2:0] kind, logic [7:0] tag,
                                              logic [9:0] len);
        t_out_item e;
        e = '0;
        e.event_kind = kind;
        e.tag_or_table_id = tag;
        e.field_length = len;
        return e;
    endfunction

    function automatic logic [9:0] len_of(logic [7:0] b);
        return {pr_shift[1:0], b} & LEN_MASK;
    endfunction

    function automatic t_pred_phase after_net_desc();
        return (pr_loop_left == 0) ? S_TSL1 : S_NTAG;
    endfunction

    function automatic t_pred_phase after_entry();
        return (pr_loop_left == 0) ? S_PAD : S_TS1;
    endfunction

    function automatic t_pred_phase after_entry_desc();
        return (pr_edesc_left == 0) ? after_entry() : S_ETAG;
    endfunction

    function automatic void with_ids(ref t_out_item e);
        e.primary_id = pr_entry_ids[31:16];
        e.original_network = pr_entry_ids[15:0];
    endfunction

    // Advance the parser model by one byte; returns 1 when an event results
    function automatic bit parse_byte(logic [7:0] b, logic start, output t_out_item e);
        t_pred_phase ph;
        ph = pr_phase;
        e = '0;
        if (start) begin
            pr_skip = b;
            pr_phase = (b != 0) ? S_SKIP : S_TID;
            return 0;
        end
        case (ph)
            S_IDLE: return 0;
            S_SKIP: begin
                pr_skip = pr_skip - 8'd1;
                if (pr_skip == 0) pr_phase = S_TID;
                return 0;
            end
            S_TID: begin
                if (b != pr_accept_tid) begin
                    e = blank_event(EV_BAD_TID, b, 10'd0);
                    pr_phase = S_IDLE;
                    return 1;
                end
                pr_tag = b;
                pr_phase = S_SL1;
                return 0;
            end
            S_SL1: begin
                pr_shift = {24'd0, b};
                pr_phase = S_SL2;
                return 0;
            end
            S_SL2: begin
                pr_sec_left = len_of(b);
                if (pr_sec_left == 0) begin
                    e = blank_event(EV_END_CRC, 8'd0, 10'd0);
                    pr_phase = S_IDLE;
                    return 1;
                end
                pr_phase = S_NID1;
                return 0;
            end
            default: ;
        endcase

        // CRC region covers the last four section bytes
        if (pr_sec_left <= 4) begin
            if (ph != S_CRC) begin
                pr_shift = '0;
                pr_phase = S_CRC;
            end
            pr_shift = {pr_shift[23:0], b};
            if (pr_sec_left > 0) pr_sec_left = pr_sec_left - 10'd1;
            if (pr_sec_left == 0) begin
                e = blank_event(EV_END_CRC, 8'd0, 10'd0);
                e.crc_value = pr_shift;
                pr_phase = S_IDLE;
                return 1;
            end
            return 0;
        end
        pr_sec_left = pr_sec_left - 10'd1;

        if (ph >= S_NTAG && ph <= S_NPAY && pr_loop_left > 0) pr_loop_left--;
        if (ph >= S_TS1 && ph <= S_EPAY && pr_loop_left > 0) pr_loop_left--;
        if (ph >= S_ETAG && ph <= S_EPAY && pr_edesc_left > 0) pr_edesc_left--;

        case (ph)
            S_NID1: begin pr_shift = {24'd0, b}; pr_phase = S_NID2; end
            S_NID2: begin pr_net_id = {pr_shift[7:0], b}; pr_phase = S_VER; end
            S_VER: begin pr_ver_flags = b[5:0]; pr_phase = S_SEC; end
            S_SEC: begin pr_sec_num = b; pr_phase = S_LAST; end
            S_LAST: begin
                e = blank_event(EV_HEADER, pr_tag, pr_sec_left + 10'd5);
                e.primary_id = pr_net_id;
                e.version = pr_ver_flags[5:1];
                e.current_next = pr_ver_flags[0];
                e.section_index = pr_sec_num;
                e.last_section_index = b;
                pr_phase = S_NDL1;
                return 1;
            end
            S_NDL1: begin pr_shift = {24'd0, b}; pr_phase = S_NDL2; end
            S_NDL2: begin pr_loop_left = len_of(b); pr_phase = after_net_desc(); end
            S_NTAG: begin pr_tag = b; pr_phase = S_NLEN; end
            S_NLEN: begin
                e = blank_event(EV_NET_HEAD, pr_tag, {2'b00, b});
                e.duplicate_tag = pr_seen[pr_tag];
                pr_seen[pr_tag] = 1'b1;
                pr_desc_left = b;
                pr_phase = (b == 0) ? after_net_desc() : S_NPAY;
                return 1;
            end
            S_NPAY: begin
                e = blank_event(EV_NET_BYTE, pr_tag, 10'd0);
                e.payload_value = b;
                pr_desc_left = pr_desc_left - 8'd1;
                if (pr_desc_left == 0) pr_phase = after_net_desc();
                return 1;
            end
            S_TSL1: begin pr_shift = {24'd0, b}; pr_phase = S_TSL2; end
            S_TSL2: begin pr_loop_left = len_of(b); pr_phase = after_entry(); end
            S_TS1, S_TS2, S_ON1, S_ON2: begin
                pr_entry_ids = {pr_entry_ids[23:0], b};
                pr_phase = t_pred_phase'(ph + 1);
            end
            S_EDL1: begin pr_shift = {24'd0, b}; pr_phase = S_EDL2; end
            S_EDL2: begin
                pr_edesc_left = len_of(b);
                e = blank_event(EV_ENTRY, 8'd0, pr_edesc_left);
                with_ids(e);
                pr_phase = after_entry_desc();
                return 1;
            end
            S_ETAG: begin pr_tag = b; pr_phase = S_ELEN; end
            S_ELEN: begin
                e = blank_event(EV_TS_HEAD, pr_tag, {2'b00, b});
                with_ids(e);
                pr_desc_left = b;
                pr_phase = (b == 0) ? after_entry_desc() : S_EPAY;
                return 1;
            end
            S_EPAY: begin
                e = blank_event(EV_TS_BYTE, pr_tag, 10'd0);
                with_ids(e);
                e.payload_value = b;
                pr_desc_left = pr_desc_left - 8'd1;
                if (pr_desc_left == 0) pr_phase = after_entry_desc();
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    // Send one byte; the expectation is queued when the byte is accepted.
    // Valid stays high into the next byte unless an idle cycle is drawn.
    task automatic send_byte(logic [7:0] b, logic start);
        t_out_item e;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{data_byte: b, section_start: start};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (parse_byte(b, start, e)) event_queue = {event_queue, e};
        byte_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (event_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_accept_tid(logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ACCEPTED_TID;
        pwdata <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pr_accept_tid = v;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_out_item exp_ev;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (event_queue.size() == 0) begin
                $error("unexpected event kind %0d", o_out.event_kind);
                fail_count++;
            end else begin
                exp_ev = event_queue.pop_front();
                event_count++;
                if (o_out.event_kind !== exp_ev.event_kind) begin
                    $error("event_kind exp %0d got %0d", exp_ev.event_kind,
                           o_out.event_kind);
                    fail_count++;
                end
                if (o_out.tag_or_table_id !== exp_ev.tag_or_table_id) begin
                    $error("tag_or_table_id exp %0h got %0h",
                           exp_ev.tag_or_table_id, o_out.tag_or_table_id);
                    fail_count++;
                end
                if (o_out.field_length !== exp_ev.field_length) begin
                    $error("field_length exp %0d got %0d", exp_ev.field_length,
                           o_out.field_length);
                    fail_count++;
                end
                if (o_out.primary_id !== exp_ev.primary_id) begin
                    $error("primary_id exp %0h got %0h", exp_ev.primary_id,
                           o_out.primary_id);
                    fail_count++;
                end
                if (o_out.original_network !== exp_ev.original_network) begin
                    $error("original_network exp %0h got %0h",
                           exp_ev.original_network, o_out.original_network);
                    fail_count++;
                end
                if (o_out.version !== exp_ev.version) begin
                    $error("version exp %0d got %0d", exp_ev.version, o_out.version);
                    fail_count++;
                end
                if (o_out.current_next !== exp_ev.current_next) begin
                    $error("current_next exp %0b got %0b", exp_ev.current_next,
                           o_out.current_next);
                    fail_count++;
                end
                if (o_out.section_index !== exp_ev.section_index) begin
                    $error("section_index exp %0d got %0d", exp_ev.section_index,
                           o_out.section_index);
                    fail_count++;
                end
                if (o_out.last_section_index !== exp_ev.last_section_index) begin
                    $error("last_section_index exp %0d got %0d",
                           exp_ev.last_section_index, o_out.last_section_index);
                    fail_count++;
                end
                if (o_out.payload_value !== exp_ev.payload_value) begin
                    $error("payload_value exp %0h got %0h", exp_ev.payload_value,
                           o_out.payload_value);
                    fail_count++;
                end
                if (o_out.duplicate_tag !== exp_ev.duplicate_tag) begin
                    $error("duplicate_tag exp %0b got %0b", exp_ev.duplicate_tag,
                           o_out.duplicate_tag);
                    fail_count++;
                end
                if (o_out.crc_value !== exp_ev.crc_value) begin
                    $error("crc_value exp %0h got %0h", exp_ev.crc_value,
                           o_out.crc_value);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= 1'b0;
    end

    // Build one section with random content, well-formed unless corrupted below
    task automatic send_section(logic [7:0] tid);
        logic [7:0] body [$];
        int n_desc;
        int n_ent;
        int dl;
        int net_len;
        int ts_len;
        int pos;
        int ptr;
        int sec_len;
        body = {};
        n_desc = $urandom_range(3, 0);
        repeat (5) body = {body, 8'($urandom)};
        // network descriptor loop
        body = {body, 8'd0, 8'd0};
        pos = body.size();
        for (int i = 0; i < n_desc; i++) begin
            dl = $urandom_range(5, 0);
            body = {body, 8'($urandom_range(15, 0)), 8'(dl)};
            repeat (dl) body = {body, 8'($urandom)};
        end
        net_len = body.size() - pos;
        body[pos - 2] = {4'($urandom), 2'($urandom), net_len[9:8]};
        body[pos - 1] = net_len[7:0];
        // transport stream loop
        body = {body, 8'd0, 8'd0};
        pos = body.size();
        n_ent = $urandom_range(2, 0);
        for (int i = 0; i < n_ent; i++) begin
            int ed_pos;
            int ed_len;
            repeat (4) body = {body, 8'($urandom)};
            body = {body, 8'd0, 8'd0};
            ed_pos = body.size();
            repeat ($urandom_range(2, 0)) begin
                dl = $urandom_range(4, 0);
                body = {body, 8'($urandom), 8'(dl)};
                repeat (dl) body = {body, 8'($urandom)};
            end
            ed_len = body.size() - ed_pos;
            body[ed_pos - 2] = {4'($urandom), 2'($urandom), ed_len[9:8]};
            body[ed_pos - 1] = ed_len[7:0];
        end
        ts_len = body.size() - pos;
        body[pos - 2] = {4'($urandom), 2'($urandom), ts_len[9:8]};
        body[pos - 1] = ts_len[7:0];
        repeat (4) body = {body, 8'($urandom)};
        sec_len = body.size();
        // occasionally corrupt one random byte
        if ($urandom_range(9, 0) == 0) body[$urandom_range(body.size() - 1, 0)] = 8'($urandom);
        ptr = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        send_byte(8'(ptr), 1'b1);
        repeat (ptr) send_byte(8'($urandom), 1'b0);
        send_byte(tid, 1'b0);
        send_byte({4'($urandom), 2'($urandom), sec_len[9:8]}, 1'b0);
        send_byte(sec_len[7:0], 1'b0);
        foreach (body[i]) send_byte(body[i], 1'b0);
    endtask

    // Directed stimulus table: byte, start, and a typed-in result where obvious
    typedef struct {
        logic [7:0] b;
        logic       start;
        bit         has_exp;
        t_out_item  exp_ev;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(logic [7:0] b, logic start);
        t_dir_row row;
        row = '{b, start, 1'b0, '0};
        dir_rows = {dir_rows, row};
    endtask

    task automatic add_row_exp(logic [7:0] b, logic start, t_out_item e);
        t_dir_row row;
        row = '{b, start, 1'b1, e};
        dir_rows = {dir_rows, row};
    endtask

    initial begin
        t_out_item e;
        fail_count = 0;
        event_count = 0;
        byte_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pr_phase = S_IDLE;
        pr_skip = '0;
        pr_sec_left = '0;
        pr_loop_left = '0;
        pr_edesc_left = '0;
        pr_desc_left = '0;
        pr_tag = '0;
        pr_shift = '0;
        pr_net_id = '0;
        pr_ver_flags = '0;
        pr_sec_num = '0;
        pr_entry_ids = '0;
        pr_accept_tid = TID_RESET;
        foreach (pr_seen[i]) pr_seen[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle noise, bad table id at reset setting, zero length,
        // short section with skip, and a long section restarted mid-section
        add_row(8'hFF, 1'b0);
        add_row(8'h00, 1'b1);
        add_row_exp(8'hFF, 1'b0, blank_event(EV_BAD_TID, 8'hFF, 10'd0));
        add_row(8'h00, 1'b1);
        add_row(8'h40, 1'b0);
        add_row(8'hFC, 1'b0);
        add_row_exp(8'h00, 1'b0, blank_event(EV_END_CRC, 8'd0, 10'd0));
        add_row(8'h02, 1'b1);
        add_row(8'hAA, 1'b0);
        add_row(8'h55, 1'b0);
        add_row(8'h40, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h02, 1'b0);
        add_row(8'hDE, 1'b0);
        add_row(8'hAD, 1'b0);
        add_row(8'h00, 1'b1);
        add_row(8'h40, 1'b0);
        add_row(8'h03, 1'b0);
        add_row(8'hFF, 1'b0);
        repeat (6) add_row(8'($urandom), 1'b0);
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].start);
            if (dir_rows[i].has_exp) begin
                e = event_queue[$];
                if (e !== dir_rows[i].exp_ev) begin
                    $error("directed row %0d predictor disagrees with table", i);
                    fail_count++;
                end
            end
        end
        send_section(TID_RESET);
        send_section(TID_RESET);
        wait_drained();

        // Random phases over several table id settings
        for (int ph = 0; ph < 8; ph++) begin
            logic [7:0] tid;
            case (ph)
                0: tid = 8'h00;
                1: tid = 8'hFF;
                default: tid = 8'($urandom);
            endcase
            write_accept_tid(tid);
            case (ph % 4)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 58; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 58; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            repeat (5) begin
                int r;
                r = $urandom_range(9, 0);
                if (r < 7) send_section(tid);
                else if (r == 7) send_section(8'($urandom));
                else repeat ($urandom_range(20, 1))
                    send_byte(8'($urandom), ($urandom_range(7, 0) == 0));
            end
            idle_pct = 0;
            stall_pct = 0;
            wait_drained();
        end
        write_accept_tid(TID_RESET);

        $display("Sent %0d bytes, checked %0d events over 9 table id settings",
                 byte_count, event_count);
        $display("with idle and stall mixes, bad ids, restarts and noise");
        if (fail_count == 0 && event_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/nisp_pkg.sv
rtl/network_info_section_parser.sv
verif/tb_top.sv
